// ===== hw/rtl/mtwd_pkg.sv =====
// Package with types and constants of the multi-task watchdog.
`default_nettype none
package mtwd_pkg;

  // Field widths
  localparam int TIME_W  = 32;
  localparam int DELTA_W = 16;
  localparam int MODE_W  = 2;
  localparam int TIDX_W  = 2;
  localparam int CNT_W   = 3;
  localparam int CIDX_W  = 3;

  // Packed stream widths, rounded up to whole bytes
  localparam int S_DATA_W = 24;
  localparam int S_USER_W = 8;
  localparam int M_DATA_W = 72;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_ADVANCE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_KICK    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CHECK   = 2'd2;

  // Register indexes
  localparam logic [CIDX_W-1:0] CFG_ACTIVE   = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_TIMEOUT0 = 3'd1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/multi_task_watchdog_top.sv =====
// Top level of the multi-task watchdog: sequencer, shared add/subtract unit, state.
//
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid/s_tready    s_tuser mode; s_tdata delta_ms, task_index
//  m_*       out        m_tvalid/m_tready    m_tdata fault .. time_now
//  cfg_*     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Advance and kick items go from accept through run and done to the result; a check
// stays in run, one task compared per cycle through the one shared adder and
// comparator, until a fault or the last active task. The input side is not ready until
// the item's result is loaded into the output register; a result waiting there stalls
// only the next item's final load. Reset clears time, kick times, timeouts and flag.
`default_nettype none
module multi_task_watchdog_top
  import mtwd_pkg::*;
#(
  parameter int TASKS = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [S_DATA_W-1:0] s_tdata,   // [15:0] delta_ms, [17:16] task_index
  input  wire logic [S_USER_W-1:0] s_tuser,   // [1:0] mode
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [M_DATA_W-1:0]      m_tdata,   // [0] fault, [2:1] fault_task,
                                              // [34:3] elapsed_ms, [35] reset_latched,
                                              // [67:36] time_now
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CIDX_W-1:0]   cfg_index,
  input  wire logic [TIME_W-1:0]   cfg_data
);

  localparam int IDX_W = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam logic [CNT_W-1:0] TASKS_CNT = CNT_W'(TASKS);

  // State and configuration
  state_t              state, state_next;
  logic [CNT_W-1:0]    active_tasks;
  logic [TIME_W-1:0]   timeout [TASKS];
  logic [TIME_W-1:0]   last_kick [TASKS];
  logic [TIME_W-1:0]   current_time;
  logic                reset_flag;

  // Latched item and scan progress
  logic [MODE_W-1:0]   mode;
  logic [DELTA_W-1:0]  delta_ms;
  logic [TIDX_W-1:0]   task_index;
  logic [CNT_W-1:0]    scan;
  logic                fault;
  logic [TIDX_W-1:0]   fault_task;
  logic [TIME_W-1:0]   elapsed_ms;

  // Shared unit
  logic [CNT_W-1:0]    active_cnt;
  logic [TIME_W-1:0]   kick_sel;
  logic [TIME_W-1:0]   unit_b;
  logic                unit_cin;
  logic [TIME_W-1:0]   unit_sum;
  logic                unit_gt;
  logic                scan_live;
  logic                scan_hit;
  logic                load_out;

  assign cfg_ready  = 1'b1;
  assign active_cnt = (active_tasks > TASKS_CNT) ? TASKS_CNT : active_tasks;
  assign scan_live  = (scan < active_cnt);
  assign kick_sel   = last_kick[scan[IDX_W-1:0]];

  // Add delta for advance, subtract last kick from time for a scan step
  assign unit_b   = (mode == MODE_ADVANCE) ? {{(TIME_W-DELTA_W){1'b0}}, delta_ms} : ~kick_sel;
  assign unit_cin = (mode != MODE_ADVANCE);
  assign unit_sum = current_time + unit_b + {{(TIME_W-1){1'b0}}, unit_cin};
  assign unit_gt  = (unit_sum > timeout[scan[IDX_W-1:0]]);
  assign scan_hit = (state == ST_RUN) && (mode == MODE_CHECK) && scan_live && unit_gt;

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Step the sequencer
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (mode != MODE_CHECK || !scan_live || unit_gt) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      active_tasks <= '0;
      for (int i = 0; i < TASKS; i++) begin
        timeout[i] <= '0;
      end
    end else if (cfg_valid) begin
      if (cfg_index == CFG_ACTIVE) begin
        active_tasks <= cfg_data[CNT_W-1:0];
      end else if (cfg_index >= CFG_TIMEOUT0 && cfg_index <= CIDX_W'(TASKS)) begin
        timeout[IDX_W'(cfg_index - CFG_TIMEOUT0)] <= cfg_data;
      end
    end
  end

  // Latch the item, run the scan, update time and kick times
  always_ff @(posedge clk) begin
    if (rst) begin
      current_time <= '0;
      reset_flag   <= 1'b0;
      scan         <= '0;
      for (int i = 0; i < TASKS; i++) begin
        last_kick[i] <= '0;
      end
    end else begin
      if (state == ST_IDLE && s_tvalid) begin
        mode       <= s_tuser[MODE_W-1:0];
        delta_ms   <= s_tdata[DELTA_W-1:0];
        task_index <= s_tdata[DELTA_W +: TIDX_W];
        scan       <= '0;
        fault      <= 1'b0;
        fault_task <= '0;
        elapsed_ms <= '0;
      end
      if (state == ST_RUN) begin
        if (mode == MODE_ADVANCE) begin
          current_time <= unit_sum;
        end
        if (mode == MODE_KICK && CNT_W'(task_index) < active_cnt) begin
          last_kick[task_index[IDX_W-1:0]] <= current_time;
        end
        if (mode == MODE_CHECK && scan_live) begin
          if (unit_gt) begin
            fault      <= 1'b1;
            fault_task <= TIDX_W'(scan);
            elapsed_ms <= unit_sum;
            reset_flag <= 1'b1;
          end else begin
            scan <= scan + CNT_W'(1);
          end
        end
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {4'b0, current_time, reset_flag, elapsed_ms, fault_task, fault};
    end
  end

`ifndef SYNTHESIS
  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item accepted while previous item in work");

  a_flag_sticky: assert property (@(posedge clk) disable iff (rst)
    reset_flag |=> reset_flag)
    else $error("reset flag cleared without reset");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    scan <= TASKS_CNT)
    else $error("scan ran past the task count");

  a_fault_latches: assert property (@(posedge clk) disable iff (rst)
    scan_hit |=> reset_flag && fault)
    else $error("fault found but not recorded");

  a_out_fault_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[35])
    else $error("result reports a fault without the latched flag");
`endif

endmodule
`default_nettype wire
